// ===== rtl/core/rvmd_pkg.sv =====
// Shared types and constants for the RV32M multiply/divide pipeline.
// No dependencies.
`default_nettype none

package rvmd_pkg;

  localparam int XLEN = 32;
  localparam int HALF = XLEN / 2;
  // divider folds its 32 iterations as DIV_STEPS per stage
  localparam int DIV_STEPS       = 4;
  localparam int DIV_ITER_STAGES = XLEN / DIV_STEPS;
  // prep stage + iteration stages + output register
  localparam int NUM_STAGES      = DIV_ITER_STAGES + 2;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } md_op_t;

  function automatic logic is_div_op(input md_op_t op);
    logic d;
    d = (op == OP_DIV) || (op == OP_DIVU) || (op == OP_REM) || (op == OP_REMU);
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rvmd_mul.sv =====
// Pipelined 32x32 multiplier: 16x16 partial products, sum, sign fix, delay line.
// Depends on rvmd_pkg.
`default_nettype none

module rvmd_mul import rvmd_pkg::*; (
  input  wire logic             clk,
  input  wire stage_vec_t       en,
  input  wire logic [2:0]       in_action,
  input  wire logic [XLEN-1:0]  in_operand_a,
  input  wire logic [XLEN-1:0]  in_operand_b,
  output logic      [XLEN-1:0]  mul_res
);

  md_op_t op;
  logic a_sgn, b_sgn;
  logic [HALF-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [XLEN-1:0] pp_ll_nxt, pp_lh_nxt, pp_hl_nxt, pp_hh_nxt, corr_nxt;

  logic [XLEN-1:0] pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r, corr_r;
  logic            hi_r;

  logic [2*XLEN-1:0] prod_nxt, prod_r;
  logic [XLEN-1:0]   corr1_r;
  logic              hi1_r;

  logic [XLEN-1:0]   res_nxt;
  logic [XLEN-1:0]   res_r [2:NUM_STAGES-2];

  assign op    = md_op_t'(in_action);
  assign a_sgn = (op == OP_MULH) || (op == OP_MULHSU);
  assign b_sgn = (op == OP_MULH);
  assign a_lo  = in_operand_a[HALF-1:0];
  assign a_hi  = in_operand_a[XLEN-1:HALF];
  assign b_lo  = in_operand_b[HALF-1:0];
  assign b_hi  = in_operand_b[XLEN-1:HALF];

  assign pp_ll_nxt = XLEN'(a_lo) * XLEN'(b_lo);
  assign pp_lh_nxt = XLEN'(a_lo) * XLEN'(b_hi);
  assign pp_hl_nxt = XLEN'(a_hi) * XLEN'(b_lo);
  assign pp_hh_nxt = XLEN'(a_hi) * XLEN'(b_hi);
  // signed high word = unsigned high word - (a<0 ? b : 0) - (b<0 ? a : 0)
  assign corr_nxt  = ((a_sgn && in_operand_a[XLEN-1]) ? in_operand_b : '0)
                   + ((b_sgn && in_operand_b[XLEN-1]) ? in_operand_a : '0);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll_r <= pp_ll_nxt;
      pp_lh_r <= pp_lh_nxt;
      pp_hl_r <= pp_hl_nxt;
      pp_hh_r <= pp_hh_nxt;
      corr_r  <= corr_nxt;
      hi_r    <= (op != OP_MUL);
    end
  end

  assign prod_nxt = {pp_hh_r, pp_ll_r}
                  + ({{XLEN{1'b0}}, pp_lh_r} << HALF)
                  + ({{XLEN{1'b0}}, pp_hl_r} << HALF);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_r  <= prod_nxt;
      corr1_r <= corr_r;
      hi1_r   <= hi_r;
    end
  end

  assign res_nxt = hi1_r ? (prod_r[2*XLEN-1:XLEN] - corr1_r) : prod_r[XLEN-1:0];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res_r[2] <= res_nxt;
    end
  end

  // delay line to line up with the divider
  for (genvar k = 3; k <= NUM_STAGES-2; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[k]) begin
        res_r[k] <= res_r[k-1];
      end
    end
  end

  assign mul_res = res_r[NUM_STAGES-2];

endmodule

`default_nettype wire

// ===== rtl/core/rvmd_div.sv =====
// Pipelined restoring divider: sign prep, DIV_STEPS iterations per stage.
// Depends on rvmd_pkg.
`default_nettype none

module rvmd_div import rvmd_pkg::*; (
  input  wire logic             clk,
  input  wire stage_vec_t       en,
  input  wire logic [2:0]       in_action,
  input  wire logic [XLEN-1:0]  in_operand_a,
  input  wire logic [XLEN-1:0]  in_operand_b,
  output logic      [XLEN-1:0]  div_res
);

  typedef struct packed {
    logic neg_q;
    logic neg_r;
    logic rem_sel;
  } div_flags_t;

  // acc = {partial remainder, dividend bits left / quotient bits so far}
  function automatic logic [2*XLEN-1:0] div_steps(input logic [2*XLEN-1:0] acc,
                                                   input logic [XLEN-1:0]   d);
    logic [2*XLEN-1:0] a;
    logic [XLEN:0]     t;
    logic [XLEN:0]     diff;
    a = acc;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t    = {a[2*XLEN-1:XLEN], a[XLEN-1]};
      diff = t - {1'b0, d};
      if (!diff[XLEN]) begin
        a = {diff[XLEN-1:0], a[XLEN-2:0], 1'b1};
      end else begin
        a = {t[XLEN-1:0], a[XLEN-2:0], 1'b0};
      end
    end
    return a;
  endfunction

  md_op_t            op;
  logic              sgn, a_neg, b_neg, b_zero;
  logic [XLEN-1:0]   a_mag, b_mag;
  div_flags_t        flags_nxt;

  logic [2*XLEN-1:0] acc_r   [0:DIV_ITER_STAGES];
  logic [XLEN-1:0]   d_r     [0:DIV_ITER_STAGES-1];
  div_flags_t        flags_r [0:DIV_ITER_STAGES];

  logic [XLEN-1:0]   quo, rem;

  assign op     = md_op_t'(in_action);
  assign sgn    = (op == OP_DIV) || (op == OP_REM);
  assign a_neg  = sgn && in_operand_a[XLEN-1];
  assign b_neg  = sgn && in_operand_b[XLEN-1];
  assign b_zero = (in_operand_b == '0);
  assign a_mag  = a_neg ? (XLEN'(0) - in_operand_a) : in_operand_a;
  assign b_mag  = b_neg ? (XLEN'(0) - in_operand_b) : in_operand_b;

  // by zero the loop yields all ones and |a|; only the quotient sign must not apply
  assign flags_nxt.neg_q   = (a_neg ^ b_neg) && !b_zero;
  assign flags_nxt.neg_r   = a_neg;
  assign flags_nxt.rem_sel = (op == OP_REM) || (op == OP_REMU);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      acc_r[0]   <= {{XLEN{1'b0}}, a_mag};
      d_r[0]     <= b_mag;
      flags_r[0] <= flags_nxt;
    end
  end

  for (genvar k = 1; k <= DIV_ITER_STAGES; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en[k]) begin
        acc_r[k]   <= div_steps(acc_r[k-1], d_r[k-1]);
        flags_r[k] <= flags_r[k-1];
      end
    end
    if (k < DIV_ITER_STAGES) begin : g_d
      always_ff @(posedge clk) begin
        if (en[k]) begin
          d_r[k] <= d_r[k-1];
        end
      end
    end
  end

  assign quo = acc_r[DIV_ITER_STAGES][XLEN-1:0];
  assign rem = acc_r[DIV_ITER_STAGES][2*XLEN-1:XLEN];

  always_comb begin
    if (flags_r[DIV_ITER_STAGES].rem_sel) begin
      div_res = flags_r[DIV_ITER_STAGES].neg_r ? (XLEN'(0) - rem) : rem;
    end else begin
      div_res = flags_r[DIV_ITER_STAGES].neg_q ? (XLEN'(0) - quo) : quo;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/riscv_m_extension_mul_div_unit.sv =====
// RV32M multiply/divide unit, top level: stage control and output register.
// Depends on rvmd_pkg, rvmd_mul, rvmd_div.
//
// Usage notes
// - Input channel: in_valid / in_stall with in_action (funct3), in_operand_a
//   (rs1) and in_operand_b (rs2). A word is taken when in_valid && !in_stall.
// - Output channel: out_valid / out_stall with out_result_value (rd value).
// - Every operation, multiply or divide, passes every stage on its way to
//   out_valid. Throughput is one word per cycle while out_stall is low.
// - Depth is set by the divider: 32 restoring iterations, 4 per stage over
//   8 stages, plus a sign-prep stage and the output register. Multiplies run
//   through 3 stages (16x16 partial products, 64-bit sum, high-word sign
//   correction) and a delay line so results leave in acceptance order.
// - Each stage has a valid bit. A stage loads when it is empty or the stage
//   after it moves, so bubbles close up under a stalled output and new words
//   are still taken; in_stall rises only when all 10 stages hold words.
// - Reset (rst_n low, synchronous) empties the pipeline; no other state.
// - Divide by zero gives all ones (DIV/DIVU) or the dividend (REM/REMU);
//   -2^31 / -1 gives -2^31, remainder 0.
`default_nettype none

module riscv_m_extension_mul_div_unit import rvmd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      in_action,
  input  wire logic [XLEN-1:0] in_operand_a,
  input  wire logic [XLEN-1:0] in_operand_b,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic      [XLEN-1:0] out_result_value
);

  stage_vec_t            en;
  stage_vec_t            v_r, v_nxt;
  logic [NUM_STAGES-2:0] isdiv_r;
  logic [XLEN-1:0]       mul_res, div_res;
  logic [XLEN-1:0]       res_r, res_nxt;

  // stage k may load when empty or when its word moves on
  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // op class travels with the word to steer the final select
  always_ff @(posedge clk) begin
    if (en[0]) begin
      isdiv_r[0] <= is_div_op(md_op_t'(in_action));
    end
    for (int k = 1; k <= NUM_STAGES-2; k++) begin
      if (en[k]) begin
        isdiv_r[k] <= isdiv_r[k-1];
      end
    end
  end

  rvmd_mul u_mul (
    .clk          (clk),
    .en           (en),
    .in_action    (in_action),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .mul_res      (mul_res)
  );

  rvmd_div u_div (
    .clk          (clk),
    .en           (en),
    .in_action    (in_action),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .div_res      (div_res)
  );

  assign res_nxt = isdiv_r[NUM_STAGES-2] ? div_res : mul_res;

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = v_r[NUM_STAGES-1];
  assign out_result_value = res_r;

  // an accepted word lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted word not captured in first stage");

  // a held stage never loses its word
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (($past(v_r) & ~$past(en)) & ~v_r) == '0)
    else $error("held stage dropped its word");

  // input is refused only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with a bubble in the pipeline");

  // the output register only empties through a completed handshake
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word vanished while stalled");

endmodule

`default_nettype wire

// ===== tb/riscv_m_extension_mul_div_unit_tb.sv =====
// Self-checking testbench for the RV32M multiply/divide unit.
// Depends on rvmd_pkg and riscv_m_extension_mul_div_unit.
// A directed table runs first, then random words, each checked against a local predictor.
`timescale 1ns / 100ps

module riscv_m_extension_mul_div_unit_tb import rvmd_pkg::*;;

  localparam int NUM_RANDOM   = 1825;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 24;     // pipeline is 10 deep; generous margin
  localparam int IDLE_PCT     = 34;

  // One row of stimulus. known marks rows whose rd value is typed in by hand.
  typedef struct {
    md_op_t          op;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic            known;
    logic [XLEN-1:0] rd;
  } md_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [2:0]      in_action = 3'd0;
  logic [XLEN-1:0] in_operand_a = '0;
  logic [XLEN-1:0] in_operand_b = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [XLEN-1:0] out_result_value;

  // Hand-typed expectation travels alongside the payload of the word on the bus.
  logic            row_known = 1'b0;
  logic [XLEN-1:0] row_rd = '0;

  logic [XLEN-1:0] pending_rd[$];   // rd values still owed by the unit, oldest first
  md_row_t         directed_rows[$];
  int              error_count = 0;
  int              cycle_count = 0;
  bit              steady_in = 1'b0;  // set: the sender never idles
  int              stall_run = 0;

  riscv_m_extension_mul_div_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted rd value. Divides work on magnitudes so -2^31 / -1 needs no
  // special handling: the magnitude 2^31 survives as an unsigned word.
  function automatic logic [XLEN-1:0] rv32m_result(input md_op_t op,
                                                   input logic [XLEN-1:0] a,
                                                   input logic [XLEN-1:0] b);
    logic [2*XLEN-1:0] prod_uu, prod_ss, prod_su;
    logic [XLEN-1:0]   mag_a, mag_b, quo, rmd;
    prod_uu = {{XLEN{1'b0}}, a} * {{XLEN{1'b0}}, b};
    prod_ss = {{XLEN{a[XLEN-1]}}, a} * {{XLEN{b[XLEN-1]}}, b};
    prod_su = {{XLEN{a[XLEN-1]}}, a} * {{XLEN{1'b0}}, b};
    mag_a   = a[XLEN-1] ? ({XLEN{1'b0}} - a) : a;
    mag_b   = b[XLEN-1] ? ({XLEN{1'b0}} - b) : b;
    quo     = '0;
    rmd     = '0;
    case (op)
      OP_MUL:    return prod_uu[XLEN-1:0];
      OP_MULH:   return prod_ss[2*XLEN-1:XLEN];
      OP_MULHSU: return prod_su[2*XLEN-1:XLEN];
      OP_MULHU:  return prod_uu[2*XLEN-1:XLEN];
      OP_DIV: begin
        if (b == '0) return '1;
        quo = mag_a / mag_b;
        return (a[XLEN-1] != b[XLEN-1]) ? ({XLEN{1'b0}} - quo) : quo;
      end
      OP_DIVU: begin
        if (b == '0) return '1;
        return a / b;
      end
      OP_REM: begin
        if (b == '0) return a;
        rmd = mag_a % mag_b;
        return a[XLEN-1] ? ({XLEN{1'b0}} - rmd) : rmd;
      end
      default: begin
        if (b == '0) return a;
        return a % b;
      end
    endcase
  endfunction

  // Operand mix: plenty of full-range words, plus the corner values and small
  // numbers so divides by zero, by one and by minus one turn up often.
  function automatic logic [XLEN-1:0] pick_operand();
    logic [XLEN-1:0] v;
    case ($urandom_range(9))
      5: begin
        case ($urandom_range(4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h0000_0001;
          2:       v = 32'hFFFF_FFFF;
          3:       v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      6:       v = XLEN'($urandom_range(15));
      7:       v = {XLEN{1'b0}} - XLEN'($urandom_range(15));
      8:       v = $urandom >> $urandom_range(31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_row(input md_op_t op, input logic [XLEN-1:0] a,
                         input logic [XLEN-1:0] b, input logic known,
                         input logic [XLEN-1:0] rd);
    md_row_t row;
    row.op    = op;
    row.a     = a;
    row.b     = b;
    row.known = known;
    row.rd    = rd;
    directed_rows.push_back(row);
  endtask

  // Present one word and hold it until the unit takes it. Idle cycles go in
  // ahead of the word; valid is only lowered when a gap is really taken, so
  // back-to-back words keep it high across the edge.
  task automatic issue_word(input md_row_t row);
    if (!steady_in) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_action    <= row.op;
    in_operand_a <= row.a;
    in_operand_b <= row.b;
    row_known    <= row.known;
    row_rd       <= row.rd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver back-pressure: mostly single stall cycles, now and then a burst
  // long enough to fill the pipeline and push in_stall high. While the sender
  // runs without gaps there is no stall at all, to exercise full throughput.
  always @(posedge clk) begin
    if (steady_in) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      case ($urandom_range(99)) inside
        [0:1]:   begin
          out_stall <= 1'b1;
          stall_run <= $urandom_range(24, 8);
        end
        [2:12]:  out_stall <= 1'b1;
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Scoreboard. The output side is checked before the input side books its
  // word, so the order within the edge is fixed whatever the latency.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_rd.size() == 0) begin
          $error("result_value with no word outstanding: actual %h", out_result_value);
          error_count <= error_count + 1;
        end else begin
          if (out_result_value !== pending_rd[0]) begin
            $error("result_value mismatch: expected %h, actual %h",
                   pending_rd[0], out_result_value);
            error_count <= error_count + 1;
          end
          void'(pending_rd.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        pending_rd.push_back(row_known ? row_rd :
                             rv32m_result(md_op_t'(in_action), in_operand_a, in_operand_b));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    md_row_t row;
    bit      force_ovf;

    // Directed table: product extremes, every action, divide by zero,
    // signed overflow and sign handling of quotient and remainder.
    add_row(OP_MUL,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000);
    add_row(OP_MUL,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001);
    add_row(OP_MUL,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(OP_MULH,   32'h8000_0000, 32'h8000_0000, 1'b1, 32'h4000_0000);
    add_row(OP_MULH,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    add_row(OP_MULH,   32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
    add_row(OP_MULHSU, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
    add_row(OP_MULHSU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_MULHU,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE);
    add_row(OP_MULHU,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0, '0);
    add_row(OP_DIV,    32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
    add_row(OP_REM,    32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    add_row(OP_DIV,    32'h0000_1234, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_DIVU,   32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_REM,    32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000);
    add_row(OP_REMU,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_DIV,    32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFD);
    add_row(OP_REM,    32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_DIV,    32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD);
    add_row(OP_REM,    32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001);
    add_row(OP_DIVU,   32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF);
    add_row(OP_DIVU,   32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
    add_row(OP_REMU,   32'hFFFF_FFFF, 32'h0000_0010, 1'b1, 32'h0000_000F);
    add_row(OP_REMU,   32'hDEAD_BEEF, 32'h0000_1234, 1'b0, '0);
    add_row(OP_DIV,    32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);

    // Single reset at the start of the run.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) issue_word(directed_rows[i]);

    // Random words, checked against the predictor. A run of words in the
    // middle goes in with no sender gaps.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      steady_in = (n >= 800 && n < 1100);
      force_ovf = ($urandom_range(49) == 0);
      row.op    = md_op_t'($urandom_range(7));
      row.a     = force_ovf ? 32'h8000_0000 : pick_operand();
      row.b     = force_ovf ? 32'hFFFF_FFFF : pick_operand();
      row.known = 1'b0;
      row.rd    = '0;
      issue_word(row);
    end
    in_valid <= 1'b0;
    // the scoreboard books the last word at the edge it was taken
    @(posedge clk);

    // Drain, then allow a few more cycles to catch any stray word.
    while (pending_rd.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_rd.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
